### src/lrup_pkg.sv
// Shared constants, types and state codes of the LRU page replacement block.
package lrup_pkg;

  // Table geometry.
  localparam int SLOTS      = 16;
  localparam int PAGE_BITS  = 16;
  localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RANK_BITS  = SLOT_BITS;
  localparam int CNT_BITS   = $clog2(SLOTS + 1);
  localparam int ENTRY_BITS = PAGE_BITS + RANK_BITS;
  localparam int FAULT_BITS = 32;

  // Register file.
  localparam int CFG_BITS   = 5;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;
  localparam logic [ADDR_BITS-1:0] REG_SLOTS_IN_USE = 3'h0;
  localparam int CFG_RESET  = (SLOTS > 31) ? 31 : SLOTS;

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [RANK_BITS-1:0]  rank_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;
  typedef logic [FAULT_BITS-1:0] fault_t;

  // Engine sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_AGE    = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

endpackage

### src/lru_page_replacement.sv
// Top level of the LRU page replacement block: register file, engine and slot memory.
//
//   Channel   Direction  Handshake              Contents
//   in        sink       in_valid / in_ready    req_page, last_request
//   out       source     out_valid / out_ready  hit, slot_index, evicted_valid,
//                                               evicted_page, fault_total
//   cfg       APB slave  psel, penable, pready  slots_in_use at byte address 0
//
// A request passes from transfer to result through a scan of the active slots and an
// aging pass over all slots, each one read a cycle through the single read port of the
// slot memory, then a decision state and the emit state that loads the result. The next
// request can transfer in the cycle after the result is loaded.
// Reset clears the valid bits and the fault count at once; no clearing pass is needed.
// A stalled result waits in the output register; the next request is taken once the
// engine has loaded it there.
module lru_page_replacement (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrup_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lrup_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lrup_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [15:0]                     req_page,
  input  logic                            last_request,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [3:0]                      slot_index,
  output logic                            evicted_valid,
  output logic [15:0]                     evicted_page,
  output logic [31:0]                     fault_total
);

  logic [lrup_pkg::CFG_BITS-1:0] slots_cfg;
  logic                          ram_rd_en;
  lrup_pkg::slot_t               ram_rd_addr;
  lrup_pkg::entry_t              ram_rd_data;
  logic                          ram_wr_en;
  lrup_pkg::slot_t               ram_wr_addr;
  lrup_pkg::entry_t              ram_wr_data;

  // Configuration registers.
  lrup_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .slots_cfg (slots_cfg)
  );

  // Slot memory: page number and recency rank per slot.
  lrup_ram #(
    .DEPTH (lrup_pkg::SLOTS),
    .WIDTH (lrup_pkg::ENTRY_BITS)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  // Search, replacement and result sequencing.
  lrup_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .slots_cfg     (slots_cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_page      (req_page),
    .last_request  (last_request),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .slot_index    (slot_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data)
  );

endmodule

### src/lrup_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lrup_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 20,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/lrup_cfg.sv
// APB-style register file holding the number of active table slots.
module lrup_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrup_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lrup_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lrup_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  output logic [lrup_pkg::CFG_BITS-1:0]   slots_cfg
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == lrup_pkg::REG_SLOTS_IN_USE);

  // The register keeps the raw written value; the engine clamps it.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_cfg <= lrup_pkg::CFG_BITS'(lrup_pkg::CFG_RESET);
    end else if (wr_hit) begin
      slots_cfg <= pwdata[lrup_pkg::CFG_BITS-1:0];
    end
  end

  // Read mux; unmapped addresses read as zero.
  always_comb begin
    if (paddr == lrup_pkg::REG_SLOTS_IN_USE) begin
      prdata = lrup_pkg::DATA_BITS'(slots_cfg);
    end else begin
      prdata = '0;
    end
  end

endmodule

### src/lrup_engine.sv
// Sequencer that scans the slot memory, picks the slot, ages the ranks and issues the result.
module lrup_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lrup_pkg::CFG_BITS-1:0]  slots_cfg,
  // Request channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    req_page,
  input  logic                           last_request,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic [3:0]                     slot_index,
  output logic                           evicted_valid,
  output logic [15:0]                    evicted_page,
  output logic [31:0]                    fault_total,
  // Slot memory port.
  output logic                           ram_rd_en,
  output lrup_pkg::slot_t                ram_rd_addr,
  input  lrup_pkg::entry_t               ram_rd_data,
  output logic                           ram_wr_en,
  output lrup_pkg::slot_t                ram_wr_addr,
  output lrup_pkg::entry_t               ram_wr_data
);

  lrup_pkg::state_t state;

  // Request held for the duration of the search.
  lrup_pkg::page_t  page_q;
  logic             last_q;
  lrup_pkg::cnt_t   n_q;
  lrup_pkg::cnt_t   n_eff;

  // Memory walk pointers.
  lrup_pkg::cnt_t   cnt;
  logic             rd_valid;
  lrup_pkg::slot_t  rd_idx;
  logic             issue;
  lrup_pkg::cnt_t   walk_end;

  // Scan findings.
  logic             found_v;
  lrup_pkg::slot_t  found_slot;
  lrup_pkg::rank_t  found_rank;
  logic             empty_v;
  lrup_pkg::slot_t  empty_slot;
  logic             oldest_v;
  lrup_pkg::slot_t  oldest_slot;
  lrup_pkg::rank_t  oldest_rank;
  lrup_pkg::page_t  oldest_page;

  // Decision and aging control.
  lrup_pkg::slot_t  slot_q;
  logic             age_all;
  lrup_pkg::rank_t  age_limit;
  logic             res_hit;
  logic             res_ev_valid;
  lrup_pkg::page_t  res_ev_page;

  // Resident state outside the memory.
  logic [lrup_pkg::SLOTS-1:0] slot_valid;
  lrup_pkg::fault_t           fault_count;

  lrup_pkg::page_t  rd_page;
  lrup_pkg::rank_t  rd_rank;

  assign rd_rank = ram_rd_data[lrup_pkg::RANK_BITS-1:0];
  assign rd_page = ram_rd_data[lrup_pkg::RANK_BITS +: lrup_pkg::PAGE_BITS];
  assign in_ready = (state == lrup_pkg::ST_IDLE);

  // Clamp the configured slot count to the range one to SLOTS.
  always_comb begin
    if (slots_cfg == '0) begin
      n_eff = lrup_pkg::CNT_BITS'(1);
    end else if (32'(slots_cfg) > 32'(lrup_pkg::SLOTS)) begin
      n_eff = lrup_pkg::CNT_BITS'(lrup_pkg::SLOTS);
    end else begin
      n_eff = lrup_pkg::CNT_BITS'(slots_cfg);
    end
  end

  // Read issue: the scan walks the active slots, the aging pass walks every slot.
  always_comb begin
    if (state == lrup_pkg::ST_AGE) begin
      walk_end = lrup_pkg::CNT_BITS'(lrup_pkg::SLOTS);
    end else begin
      walk_end = n_q;
    end
    issue       = ((state == lrup_pkg::ST_SCAN) || (state == lrup_pkg::ST_AGE)) &&
                  (cnt < walk_end);
    ram_rd_en   = issue;
    ram_rd_addr = cnt[lrup_pkg::SLOT_BITS-1:0];
  end

  // Aging write-back: the chosen slot takes the request page at rank zero, and every other
  // valid slot more recent than the limit (all of them when a free slot was filled) moves one rank older.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = rd_idx;
    ram_wr_data = {rd_page, rd_rank + lrup_pkg::RANK_BITS'(1)};
    if ((state == lrup_pkg::ST_AGE) && rd_valid) begin
      if (rd_idx == slot_q) begin
        ram_wr_en   = 1'b1;
        ram_wr_data = {page_q, lrup_pkg::rank_t'(0)};
      end else if (slot_valid[rd_idx] && (age_all || (rd_rank < age_limit))) begin
        ram_wr_en   = 1'b1;
      end
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lrup_pkg::ST_IDLE;
      cnt         <= '0;
      rd_valid    <= 1'b0;
      slot_valid  <= '0;
      fault_count <= '0;
      out_valid   <= 1'b0;
      found_v     <= 1'b0;
      empty_v     <= 1'b0;
      oldest_v    <= 1'b0;
    end else begin
      // A result transfer frees the output register; the emit state reloads it itself.
      if (out_valid && out_ready && (state != lrup_pkg::ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        lrup_pkg::ST_IDLE: begin
          if (in_valid) begin
            page_q   <= lrup_pkg::page_t'(req_page);
            last_q   <= last_request;
            n_q      <= n_eff;
            cnt      <= '0;
            found_v  <= 1'b0;
            empty_v  <= 1'b0;
            oldest_v <= 1'b0;
            state    <= lrup_pkg::ST_SCAN;
          end
        end

        lrup_pkg::ST_SCAN: begin
          rd_valid <= issue;
          rd_idx   <= cnt[lrup_pkg::SLOT_BITS-1:0];
          cnt      <= cnt + lrup_pkg::CNT_BITS'(issue);
          // Search the entry read in the previous cycle, lowest index first.
          if (rd_valid) begin
            if (slot_valid[rd_idx]) begin
              if (!found_v && (rd_page == page_q)) begin
                found_v    <= 1'b1;
                found_slot <= rd_idx;
                found_rank <= rd_rank;
              end
              if (!oldest_v || (rd_rank > oldest_rank)) begin
                oldest_v    <= 1'b1;
                oldest_slot <= rd_idx;
                oldest_rank <= rd_rank;
                oldest_page <= rd_page;
              end
            end else if (!empty_v) begin
              empty_v    <= 1'b1;
              empty_slot <= rd_idx;
            end
          end
          if (!issue && !rd_valid) begin
            state <= lrup_pkg::ST_DECIDE;
          end
        end

        lrup_pkg::ST_DECIDE: begin
          cnt          <= '0;
          res_hit      <= found_v;
          res_ev_valid <= 1'b0;
          res_ev_page  <= '0;
          if (found_v) begin
            slot_q    <= found_slot;
            age_all   <= 1'b0;
            age_limit <= found_rank;
          end else begin
            if (fault_count != '1) begin
              fault_count <= fault_count + lrup_pkg::FAULT_BITS'(1);
            end
            if (empty_v) begin
              slot_q    <= empty_slot;
              age_all   <= 1'b1;
              age_limit <= found_rank;
              slot_valid[empty_slot] <= 1'b1;
            end else begin
              slot_q       <= oldest_slot;
              age_all      <= 1'b0;
              age_limit    <= oldest_rank;
              res_ev_valid <= 1'b1;
              res_ev_page  <= oldest_page;
            end
          end
          state <= lrup_pkg::ST_AGE;
        end

        lrup_pkg::ST_AGE: begin
          rd_valid <= issue;
          rd_idx   <= cnt[lrup_pkg::SLOT_BITS-1:0];
          cnt      <= cnt + lrup_pkg::CNT_BITS'(issue);
          if (!issue && !rd_valid) begin
            state <= lrup_pkg::ST_EMIT;
          end
        end

        lrup_pkg::ST_EMIT: begin
          // Load the output register once it is free, then apply the end-of-sequence clear.
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            hit           <= res_hit;
            slot_index    <= 4'(slot_q);
            evicted_valid <= res_ev_valid;
            evicted_page  <= 16'(res_ev_page);
            fault_total   <= 32'(fault_count);
            if (last_q) begin
              slot_valid  <= '0;
              fault_count <= '0;
            end
            state <= lrup_pkg::ST_IDLE;
          end
        end

        default: begin
          state <= lrup_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for the LRU page replacement block, with a table predictor.
module tb;
  import lrup_pkg::*;

  // Kinds of rows in the directed table.
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // Stall patterns of the result receiver.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW} rx_mode_t;

  typedef struct packed {
    logic   hit;
    slot_t  slot;
    logic   ev_valid;
    page_t  ev_page;
    fault_t faults;
  } lru_result_t;

  // A request row carries the page in value; a register row carries the slot count.
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    logic        is_last;
    logic        typed;
    lru_result_t res;
  } dir_row_t;

  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_REQS = 1430;
  localparam int TAIL_CYCLES = 60;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel, penable, pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata, prdata;
  logic                 pready;
  logic                 in_valid, in_ready;
  logic [15:0]          req_page;
  logic                 last_request;
  logic                 out_valid, out_ready;
  logic                 hit;
  logic [3:0]           slot_index;
  logic                 evicted_valid;
  logic [15:0]          evicted_page;
  logic [31:0]          fault_total;

  // Predicted copy of the page table and the register.
  page_t       tab_page  [SLOTS];
  logic        tab_valid [SLOTS];
  rank_t       tab_rank  [SLOTS];
  fault_t      fault_cnt;
  logic [4:0]  cfg_slots;

  lru_result_t pending_results[$];
  int          n_errors  = 0;
  int          burst_left = 0;
  logic        hold_req  = 1'b0;

  // Directed rows: the typed results follow from an empty table by hand.
  dir_row_t dir_rows [21] = '{
    '{ROW_REQ, 16'h0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
    '{ROW_REQ, 16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
    '{ROW_REQ, 16'h0000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
    '{ROW_REQ, 16'hFFFF, 1'b1, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd2}},
    '{ROW_REQ, 16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
    '{ROW_CFG, 16'd0,    1'b0, 1'b0, '0},
    '{ROW_REQ, 16'h1234, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'hFFFF, 32'd2}},
    '{ROW_REQ, 16'h1234, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
    '{ROW_REQ, 16'h5678, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h1234, 32'd3}},
    '{ROW_CFG, 16'd2,    1'b0, 1'b0, '0},
    '{ROW_REQ, 16'hAAAA, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd4}},
    '{ROW_REQ, 16'h5555, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h5678, 32'd5}},
    '{ROW_REQ, 16'hAAAA, 1'b0, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd5}},
    '{ROW_REQ, 16'h0F0F, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h5555, 32'd6}},
    '{ROW_CFG, 16'd31,   1'b0, 1'b0, '0},
    '{ROW_REQ, 16'h5555, 1'b0, 1'b0, '0},
    '{ROW_CFG, 16'd1,    1'b0, 1'b0, '0},
    '{ROW_REQ, 16'hAAAA, 1'b0, 1'b0, '0},
    '{ROW_CFG, 16'd16,   1'b0, 1'b0, '0},
    '{ROW_REQ, 16'hAAAA, 1'b0, 1'b0, '0},
    '{ROW_REQ, 16'h0000, 1'b1, 1'b0, '0}
  };

  lru_page_replacement uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_page      (req_page),
    .last_request  (last_request),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .slot_index    (slot_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

  always #5 clk = ~clk;

  // Make every valid slot more recent than limit one step older.
  function automatic void age_slots(input int limit);
    for (int k = 0; k < SLOTS; k++)
      if (tab_valid[k] && int'(tab_rank[k]) < limit)
        tab_rank[k] = tab_rank[k] + 1'b1;
  endfunction

  // Look up one page, update the predicted table and return the expected result.
  function automatic lru_result_t lru_access(input page_t pg, input logic is_last);
    lru_result_t r;
    int          active;
    int          found;
    int          empty;
    int          oldest;
    int          s;
    r      = '0;
    active = (cfg_slots == 0) ? 1 : ((cfg_slots > SLOTS) ? SLOTS : int'(cfg_slots));
    found  = -1;
    empty  = -1;
    oldest = -1;
    for (int k = 0; k < active; k++) begin
      if (tab_valid[k]) begin
        if (found < 0 && tab_page[k] == pg) found = k;
        if (oldest < 0 || tab_rank[k] > tab_rank[oldest]) oldest = k;
      end else if (empty < 0) begin
        empty = k;
      end
    end
    if (found >= 0) begin
      s     = found;
      r.hit = 1'b1;
      age_slots(int'(tab_rank[s]));
    end else begin
      if (fault_cnt != '1) fault_cnt = fault_cnt + 1'b1;
      if (empty >= 0) begin
        s = empty;
        age_slots(SLOTS + 1);
      end else begin
        s          = oldest;
        r.ev_valid = 1'b1;
        r.ev_page  = tab_page[s];
        age_slots(int'(tab_rank[s]));
      end
      tab_page[s]  = pg;
      tab_valid[s] = 1'b1;
    end
    tab_rank[s] = '0;
    r.slot      = slot_t'(s);
    r.faults    = fault_cnt;
    // The last request of a sequence empties the table after its result.
    if (is_last) begin
      for (int k = 0; k < SLOTS; k++) begin
        tab_valid[k] = 1'b0;
        tab_rank[k]  = '0;
      end
      fault_cnt = '0;
    end
    return r;
  endfunction

  // Offer one request until its transfer and queue what it should produce.
  task automatic send_request(input page_t pg, input logic is_last, input logic typed,
                              input lru_result_t typed_res);
    lru_result_t r;
    in_valid     = 1'b1;
    req_page     = pg;
    last_request = is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = lru_access(pg, is_last);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // Sender bursts: a random gap with valid low once each burst is used up.
  task automatic pace_sender();
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Hold requests back until every expected result has been seen.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the slot count over the register port, then read it back.
  task automatic write_slot_count(input logic [4:0] v);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = REG_SLOTS_IN_USE;
    pwdata  = DATA_BITS'(v);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cfg_slots = v;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_BITS'(v)) begin
      $error("prdata: expected %0d, got %0d", v, prdata);
      n_errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Receiver: switches between stall patterns, with one long hold on request.
  initial begin : receiver
    rx_mode_t mode;
    int       left;
    out_ready = 1'b0;
    mode      = RX_OPEN;
    left      = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        left = $urandom_range(10, 150);
      end else begin
        left--;
      end
      case (mode)
        RX_OPEN: out_ready = 1'b1;
        RX_COIN: out_ready = $urandom_range(0, 1);
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    lru_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: slot %0d page %0h", slot_index, evicted_page);
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, hit);
          n_errors++;
        end
        if (slot_index !== e.slot) begin
          $error("slot_index: expected %0d, got %0d", e.slot, slot_index);
          n_errors++;
        end
        if (evicted_valid !== e.ev_valid) begin
          $error("evicted_valid: expected %0d, got %0d", e.ev_valid, evicted_valid);
          n_errors++;
        end
        if (evicted_page !== e.ev_page) begin
          $error("evicted_page: expected %0h, got %0h", e.ev_page, evicted_page);
          n_errors++;
        end
        if (fault_total !== e.faults) begin
          $error("fault_total: expected %0d, got %0d", e.faults, fault_total);
          n_errors++;
        end
      end
    end
  end

  // Stimulus: directed table, then random sequences over small working sets.
  initial begin : stimulus
    page_t      ws [24];
    int         ws_size;
    int         seq_len;
    int         reqs;
    int         seq;
    page_t      pg;
    logic       is_last;
    logic [4:0] cfg_pick;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_page     = '0;
    last_request = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    for (int k = 0; k < SLOTS; k++) begin
      tab_page[k]  = '0;
      tab_valid[k] = 1'b0;
      tab_rank[k]  = '0;
    end
    fault_cnt = '0;
    cfg_slots = 5'(SLOTS);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows, with register writes only once the block is empty.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_slot_count(dir_rows[i].value[4:0]);
      end else begin
        pace_sender();
        send_request(dir_rows[i].value, dir_rows[i].is_last, dir_rows[i].typed,
                     dir_rows[i].res);
      end
    end

    // Random sequences: mostly repeats from a working set, some stray pages.
    reqs = 0;
    seq  = 0;
    while (reqs < RANDOM_REQS) begin
      if (seq == 0 || $urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       cfg_pick = 5'd0;
          1:       cfg_pick = 5'd1;
          2:       cfg_pick = 5'd31;
          3:       cfg_pick = 5'(SLOTS);
          default: cfg_pick = 5'($urandom_range(0, 31));
        endcase
        drain_results();
        write_slot_count(cfg_pick);
      end
      ws_size = $urandom_range(1, 24);
      for (int k = 0; k < ws_size; k++) ws[k] = page_t'($urandom);
      seq_len = $urandom_range(10, 120);
      // The final sequence stops at the request budget.
      if (seq_len > RANDOM_REQS - reqs) seq_len = RANDOM_REQS - reqs;
      for (int j = 0; j < seq_len; j++) begin
        if ($urandom_range(0, 9) == 0) pg = page_t'($urandom);
        else                           pg = ws[$urandom_range(0, ws_size - 1)];
        if (j == seq_len - 1) is_last = ($urandom_range(0, 3) != 0);
        else                  is_last = ($urandom_range(0, 99) == 0);
        // Stall the receiver for a long stretch while requests keep coming.
        if (seq == 2 && j == 3) hold_req = 1'b1;
        pace_sender();
        send_request(pg, is_last, 1'b0, '0);
        reqs++;
      end
      // Pause the sender once until the block has emptied.
      if (seq == 5) drain_results();
      seq++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("tb: PASS");
    else               $display("tb: FAIL");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #6_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
